// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the comment stripper.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define CCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("comment stripper check failed");

// Concurrent check that also holds through reset.
`define CCS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("comment stripper check failed");

`endif

// File: hw/rtl/ccs_pkg.sv
// Types and constants for the C comment stripper.
// No dependencies; used by the top level, the checker and the testbench.
package ccs_pkg;

   // character codes
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_LINE   = 3'd2,
      MODE_BLOCK  = 3'd3,
      MODE_STRING = 3'd4,
      MODE_CHAR   = 3'd5
   } scan_mode_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_text;
      logic       unterminated;
   } rsp_item_type;

endpackage

// File: hw/rtl/ccs_if.sv
// Request and response channel interfaces of the C comment stripper.
// Depends on nothing but plain logic types.
interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       end_of_text;
   logic       unterminated;

   modport source (output valid, output has_byte, output out_byte, output last_of_run,
                   output end_of_text, output unterminated, input ready);
   modport sink   (input valid, input has_byte, input out_byte, input last_of_run,
                   input end_of_text, input unterminated, output ready);
endinterface

// File: hw/rtl/c_comment_stripper_unit.sv
// C comment stripper: one source byte per request, up to two result bytes out.
// Results of an accepted request go into the result queue and leave on rsp in order.
// Throughput: one request per cycle while req is ready; a request giving two results writes both,
// and the 4-entry result queue keeps req ready while no more than two results wait.
// Reset (synchronous, active high): scanner back to normal text, result queue empty.
// Depends on ccs_pkg and the channel interfaces in ccs_if.sv.
module c_comment_stripper_unit
   import ccs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ccs_req_if.sink   req_bus,
   ccs_rsp_if.source rsp_bus
);

   // ---------------------------------------------------------------------
   // Scanner state
   // ---------------------------------------------------------------------
   scan_mode_type mode_ff, mode_in;
   logic          esc_ff, esc_in;     // unpaired backslash inside a literal
   logic          star_ff, star_in;   // previous block-comment byte was '*'

   // ---------------------------------------------------------------------
   // Result queue: small register file, up to two writes per cycle
   // ---------------------------------------------------------------------
   rsp_item_type         q_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;

   logic       req_fire;
   logic       rsp_pop;
   logic [7:0] b;
   logic       last;

   assign b        = req_bus.in_byte;
   assign last     = req_bus.in_last;
   // room for two more results, judged on registered occupancy only
   assign req_bus.ready = (cnt_ff < RSP_CNT_W'(RSP_DEPTH - 1));
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_pop  = rsp_bus.valid && rsp_bus.ready;

   // ---------------------------------------------------------------------
   // Normal-text handling of the current byte (used in normal mode and
   // after a held slash that turns out not to open a comment)
   // ---------------------------------------------------------------------
   scan_mode_type nb_mode;
   logic          nb_emit;
   logic          nb_clr_esc;

   always_comb begin
      nb_mode    = MODE_NORMAL;
      nb_emit    = 1'b1;
      nb_clr_esc = 1'b0;
      priority if (b == CH_DQUOTE) begin
         nb_mode    = MODE_STRING;
         nb_clr_esc = 1'b1;
      end else if (b == CH_SQUOTE) begin
         nb_mode    = MODE_CHAR;
         nb_clr_esc = 1'b1;
      end else if (b == CH_SLASH) begin
         // hold the slash unless it ends the text
         if (!last) begin
            nb_mode = MODE_SLASH;
            nb_emit = 1'b0;
         end
      end else begin
         nb_emit = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Scanner step
   // ---------------------------------------------------------------------
   scan_mode_type step_mode;
   logic          step_esc;
   logic          step_star;
   logic [1:0]    n_emit;
   logic [7:0]    byte0, byte1;
   logic [7:0]    quote;
   logic          unterm;

   always_comb begin
      step_mode = mode_ff;
      step_esc  = esc_ff;
      step_star = star_ff;
      n_emit    = 2'd0;
      byte0     = b;
      byte1     = b;
      quote     = (mode_ff == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;
      unique case (mode_ff)
         MODE_STRING, MODE_CHAR: begin
            n_emit = 2'd1;
            if (b == quote && !esc_ff) begin
               step_mode = MODE_NORMAL;
            end
            step_esc = (b == CH_BSLASH) ? !esc_ff : 1'b0;
            if (b == CH_NL) begin
               step_mode = MODE_NORMAL;
               step_esc  = 1'b0;
            end
         end
         MODE_LINE: begin
            if (b == CH_NL) begin
               step_mode = MODE_NORMAL;
               n_emit    = 2'd1;
            end
         end
         MODE_BLOCK: begin
            if (b == CH_SLASH && star_ff) begin
               step_mode = MODE_NORMAL;
               step_star = 1'b0;
            end else begin
               if (b == CH_NL) begin
                  n_emit = 2'd1;
               end
               step_star = (b == CH_STAR);
            end
         end
         MODE_SLASH: begin
            priority if (b == CH_SLASH) begin
               step_mode = MODE_LINE;
            end else if (b == CH_STAR) begin
               // the opener's star cannot also close the comment
               step_mode = MODE_BLOCK;
               step_star = 1'b0;
               n_emit    = 2'd1;
               byte0     = CH_SPACE;
            end else begin
               // held slash goes out, then the byte as normal text
               byte0     = CH_SLASH;
               step_mode = nb_mode;
               n_emit    = nb_emit ? 2'd2 : 2'd1;
               if (nb_clr_esc) begin
                  step_esc = 1'b0;
               end
            end
         end
         default: begin
            step_mode = nb_mode;
            n_emit    = nb_emit ? 2'd1 : 2'd0;
            if (nb_clr_esc) begin
               step_esc = 1'b0;
            end
         end
      endcase
      unterm = (step_mode == MODE_BLOCK) || (step_mode == MODE_STRING) ||
               (step_mode == MODE_CHAR);
   end

   // ---------------------------------------------------------------------
   // Result items of this request
   // ---------------------------------------------------------------------
   rsp_item_type item0, item1;
   logic [1:0]   n_wr;

   always_comb begin
      n_wr = n_emit;
      if (n_emit == 2'd0 && last) begin
         n_wr = 2'd1;     // silent final byte still reports end of text
      end
      item0.has_byte     = (n_emit != 2'd0);
      item0.out_byte     = (n_emit != 2'd0) ? byte0 : 8'h00;
      item0.last_of_run  = (n_emit != 2'd2);
      item0.end_of_text  = (n_emit != 2'd2) && last;
      item0.unterminated = (n_emit != 2'd2) && last && unterm;
      item1.has_byte     = 1'b1;
      item1.out_byte     = byte1;
      item1.last_of_run  = 1'b1;
      item1.end_of_text  = last;
      item1.unterminated = last && unterm;
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      mode_in = mode_ff;
      esc_in  = esc_ff;
      star_in = star_ff;
      if (req_fire) begin
         if (last) begin
            // end of text: the next byte starts a fresh text
            mode_in = MODE_NORMAL;
            esc_in  = 1'b0;
            star_in = 1'b0;
         end else begin
            mode_in = step_mode;
            esc_in  = step_esc;
            star_in = step_star;
         end
      end
   end

   assign wr_ptr_nx = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(n_wr);
      end
      if (rsp_pop) begin
         rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(1);
      end
      cnt_in = cnt_ff + (req_fire ? RSP_CNT_W'(n_wr) : RSP_CNT_W'(0))
                      - (rsp_pop ? RSP_CNT_W'(1) : RSP_CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         esc_ff    <= 1'b0;
         star_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         esc_ff    <= esc_in;
         star_ff   <= star_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (req_fire && n_wr != 2'd0) begin
         q_mem[wr_ptr_ff] <= item0;
      end
      if (req_fire && n_wr == 2'd2) begin
         q_mem[wr_ptr_nx] <= item1;
      end
   end

   // ---------------------------------------------------------------------
   // Response channel
   // ---------------------------------------------------------------------
   rsp_item_type head;

   assign head                 = q_mem[rd_ptr_ff];
   assign rsp_bus.valid        = (cnt_ff != '0);
   assign rsp_bus.has_byte     = head.has_byte;
   assign rsp_bus.out_byte     = head.out_byte;
   assign rsp_bus.last_of_run  = head.last_of_run;
   assign rsp_bus.end_of_text  = head.end_of_text;
   assign rsp_bus.unterminated = head.unterminated;

endmodule

// File: hw/rtl/ccs_checker.sv
// Port-level checks for the C comment stripper, bound to its top level.
// Depends on assert_macros.svh and ccs_pkg.
`include "assert_macros.svh"

module ccs_checker
   import ccs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       has_byte,
   input logic [7:0] out_byte,
   input logic       last_of_run,
   input logic       end_of_text,
   input logic       unterminated
);

   rsp_item_type rsp_item;

   assign rsp_item = '{has_byte, out_byte, last_of_run, end_of_text, unterminated};

   // stalled response keeps its contents
   `CCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))

   // queue comes out of reset empty
   `CCS_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

   // a result without a byte only closes a text
   `CCS_ASSERT(a_empty_is_eot, clock, reset, rsp_valid && !has_byte |-> end_of_text && last_of_run && out_byte == 8'h00)

   // unterminated and end of text only on the closing result of a run
   `CCS_ASSERT(a_eot_closes, clock, reset, rsp_valid && (unterminated || end_of_text) |-> end_of_text && last_of_run)

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .has_byte     (rsp_bus.has_byte),
   .out_byte     (rsp_bus.out_byte),
   .last_of_run  (rsp_bus.last_of_run),
   .end_of_text  (rsp_bus.end_of_text),
   .unterminated (rsp_bus.unterminated)
);

// File: tb/tb_top.sv
// Testbench for c_comment_stripper_unit: directed and random C text with a scoreboard.
// Depends on ccs_pkg, the channel interfaces in ccs_if.sv and the unit itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ccs_pkg::*;

   localparam int TEXT_REQUESTS = 800;  // random part stops after about this many requests
   localparam int IDLE_LIMIT    = 400;  // cycles with no handshake before giving up
   localparam int END_CYCLES    = 12;   // settle time once nothing is outstanding

   // Scoreboard: tracks the scanner state of the unit and keeps the bytes
   // each request should produce, oldest first.
   class strip_scoreboard;
      scan_mode_type mode;
      bit            escaped;    // last literal byte was an unpaired backslash
      bit            star_prev;  // last block comment byte was '*'
      logic [7:0]    emitted[$];
      rsp_item_type  expected_q[$];
      int            errors;

      function new();
         clear();
         errors = 0;
      endfunction

      function void clear();
         mode      = MODE_NORMAL;
         escaped   = 1'b0;
         star_prev = 1'b0;
      endfunction

      // plain text, no slash held
      function void plain_byte(logic [7:0] b, bit last);
         if (b == CH_DQUOTE) begin
            mode    = MODE_STRING;
            escaped = 1'b0;
            emitted.push_back(b);
         end else if (b == CH_SQUOTE) begin
            mode    = MODE_CHAR;
            escaped = 1'b0;
            emitted.push_back(b);
         end else if (b == CH_SLASH) begin
            if (last)
               emitted.push_back(b);
            else
               mode = MODE_SLASH;
         end else begin
            emitted.push_back(b);
         end
      endfunction

      function void quoted_byte(logic [7:0] b, logic [7:0] quote);
         emitted.push_back(b);
         if (b == quote && !escaped)
            mode = MODE_NORMAL;
         escaped = (b == CH_BSLASH) ? !escaped : 1'b0;
         if (b == CH_NL) begin
            mode    = MODE_NORMAL;
            escaped = 1'b0;
         end
      endfunction

      function void note_request(logic [7:0] b, bit last);
         bit           open_end;
         bit           fin;
         int           n;
         rsp_item_type r;
         emitted.delete();
         case (mode)
            MODE_STRING: quoted_byte(b, CH_DQUOTE);
            MODE_CHAR:   quoted_byte(b, CH_SQUOTE);
            MODE_LINE: begin
               if (b == CH_NL) begin
                  mode = MODE_NORMAL;
                  emitted.push_back(CH_NL);
               end
            end
            MODE_BLOCK: begin
               if (b == CH_SLASH && star_prev) begin
                  mode      = MODE_NORMAL;
                  star_prev = 1'b0;
               end else begin
                  if (b == CH_NL)
                     emitted.push_back(CH_NL);
                  star_prev = (b == CH_STAR);
               end
            end
            MODE_SLASH: begin
               if (b == CH_SLASH) begin
                  mode = MODE_LINE;
               end else if (b == CH_STAR) begin
                  mode      = MODE_BLOCK;
                  star_prev = 1'b0;
                  emitted.push_back(CH_SPACE);
               end else begin
                  emitted.push_back(CH_SLASH);
                  mode = MODE_NORMAL;
                  plain_byte(b, last);
               end
            end
            default: begin
               mode = MODE_NORMAL;
               plain_byte(b, last);
            end
         endcase
         open_end = (mode == MODE_BLOCK) || (mode == MODE_STRING) || (mode == MODE_CHAR);
         n = emitted.size();
         for (int k = 0; k < n; k++) begin
            fin            = (k == n - 1);
            r.has_byte     = 1'b1;
            r.out_byte     = emitted[k];
            r.last_of_run  = fin;
            r.end_of_text  = fin && last;
            r.unterminated = fin && last && open_end;
            expected_q.push_back(r);
         end
         // silent final byte still closes the text with an empty result
         if (n == 0 && last) begin
            r.has_byte     = 1'b0;
            r.out_byte     = 8'h00;
            r.last_of_run  = 1'b1;
            r.end_of_text  = 1'b1;
            r.unterminated = open_end;
            expected_q.push_back(r);
         end
         if (last)
            clear();
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: has_byte %0b out_byte %h", got.has_byte, got.out_byte);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
            errors++;
         end
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            errors++;
         end
         if (got.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %0b, got %0b", want.end_of_text, got.end_of_text);
            errors++;
         end
         if (got.unterminated !== want.unterminated) begin
            $error("unterminated: expected %0b, got %0b", want.unterminated, got.unterminated);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ccs_req_if req_bus ();
   ccs_rsp_if rsp_bus ();

   c_comment_stripper_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   strip_scoreboard sb;
   bit              quiet;          // both sides run without idle gaps while set
   int              requests_sent;
   int              idle_cycles;
   logic [7:0]      text_q[$];      // bytes of the text being built

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Every input known from time zero; the scoreboard exists before the first edge.
   initial begin
      sb               = new();
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.in_byte  = 8'h00;
      req_bus.in_last  = 1'b0;
      rsp_bus.ready    = 1'b0;
      quiet            = 1'b0;
      requests_sent    = 0;
      idle_cycles      = 0;
   end

   // Monitor: both channels sampled at the rising edge. A request is predicted
   // the moment it is accepted; its results cannot appear before the next edge.
   always @(posedge clock) begin
      rsp_item_type got;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.in_byte, req_bus.in_last);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.has_byte     = rsp_bus.has_byte;
            got.out_byte     = rsp_bus.out_byte;
            got.last_of_run  = rsp_bus.last_of_run;
            got.end_of_text  = rsp_bus.end_of_text;
            got.unterminated = rsp_bus.unterminated;
            sb.check_response(got);
            moved = 1'b1;
         end
         // watchdog: no handshake on either side for too long means a hang
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("no handshake for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result side: ready drops for a random stall before each result, except
   // in quiet stretches. Ready only changes on the falling edge.
   initial begin
      int stall;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // One request: optional gap with valid low, then hold until accepted.
   // Called and returns on a falling edge; valid is never dropped and
   // raised in the same step.
   task automatic send_request(input logic [7:0] b, input bit last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      requests_sent++;
   endtask

   // whole text from a literal, final byte flagged as last when asked
   task automatic send_text(input string s, input bit close_text);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], close_text && (i == s.len() - 1));
   endtask

   // hold the sender until the unit has delivered everything owed;
   // valid is driven low meanwhile
   task automatic wait_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // bytes that matter to the scanner, weighted toward quotes, slashes and stars
   function automatic logic [7:0] pick_char();
      string pool = "ab */\\\"'\nx*/;";
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   // Random well-formed-ish C text: identifiers, literals with escapes, both
   // comment kinds, lone slashes, raw bytes. Some literals and block comments
   // are left open on purpose.
   task automatic build_text();
      int tokens;
      text_q.delete();
      tokens = $urandom_range(1, 12);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1: text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
            2: begin
               text_q.push_back(CH_DQUOTE);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 2) == 0)
                     text_q.push_back(CH_BSLASH);
                  text_q.push_back(pick_char());
               end
               if ($urandom_range(0, 7) != 0)
                  text_q.push_back(CH_DQUOTE);
            end
            3: begin
               text_q.push_back(CH_SQUOTE);
               if ($urandom_range(0, 1) == 0)
                  text_q.push_back(CH_BSLASH);
               text_q.push_back(pick_char());
               text_q.push_back(CH_SQUOTE);
            end
            4: begin
               text_q.push_back(CH_SLASH);
               text_q.push_back(CH_SLASH);
               repeat ($urandom_range(0, 5)) text_q.push_back(pick_char());
               text_q.push_back(CH_NL);
            end
            5: begin
               text_q.push_back(CH_SLASH);
               text_q.push_back(CH_STAR);
               repeat ($urandom_range(0, 6)) text_q.push_back(pick_char());
               if ($urandom_range(0, 7) != 0) begin
                  text_q.push_back(CH_STAR);
                  text_q.push_back(CH_SLASH);
               end
            end
            6: begin
               text_q.push_back(CH_SLASH);
               text_q.push_back(pick_char());
            end
            7: text_q.push_back(8'($urandom_range(0, 255)));
            8: text_q.push_back(CH_NL);
            default: text_q.push_back(pick_char());
         endcase
      end
   endtask

   initial begin
      int n;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // zero byte, held slash before a plain byte, top byte value, final slash
      send_request(8'h00, 1'b0);
      send_text("/x", 1'b0);
      send_request(8'hFF, 1'b0);
      send_text("/", 1'b1);
      // opener star cannot close; newline kept inside; silent final byte
      send_text("/*/\n*/", 1'b1);
      // escaped quote stays inside the string, newline ends it
      send_text("\"a\\\"\n", 1'b1);
      // char literal left open by an escaped quote
      send_text("'\\'", 1'b1);
      // line comment, newline kept
      send_text("//x\n", 1'b1);
      // text ends inside a block comment
      send_text("/*", 1'b1);
      wait_results();

      // --- random ---
      while (requests_sent < TEXT_REQUESTS) begin
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            // raw noise, sometimes cut by a last flag mid stream
            repeat ($urandom_range(1, 8))
               send_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            build_text();
            n = text_q.size();
            for (int i = 0; i < n; i++)
               send_request(text_q[i], i == n - 1);
         end
         if ($urandom_range(0, 9) == 0)
            wait_results();
      end
      quiet = 1'b0;

      wait_results();
      repeat (END_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
